// ----- rtl/core/release_tag_version_checker_macros.svh -----
// ----------------------------------------------------------------------------
// Release tag version checker: assertion macros
// Shared property templates for the checker RTL.
// ----------------------------------------------------------------------------
`ifndef RELEASE_TAG_VERSION_CHECKER_MACROS_SVH
`define RELEASE_TAG_VERSION_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RTVC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtvc assertion failed");

// Next-cycle implication, disabled during reset.
`define RTVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtvc assertion failed");

`endif

// ----- rtl/core/rtvc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtvc_pkg
// Types, constants and character classes for the release tag checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtvc_pkg;

  localparam logic [4:0] MAX_NAME_OFFSET = 5'd17;
  localparam logic [6:0] COUNT_TOP       = 7'd127;
  localparam logic [5:0] MAX_LEN_RESET   = 6'd32;
  localparam logic [3:0] REFS_LEN        = 4'd10;
  localparam logic [3:0] PKGPFX_LEN      = 4'd7;
  localparam logic [4:0] REFS_BASE       = 5'd10;

  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_UP_V   = 8'h56;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_UP_R   = 8'h52;
  localparam logic [7:0] CH_LOW_D  = 8'h64;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_AT     = 8'h40;

  typedef enum logic [2:0] {
    PH_START,
    PH_REFS,
    PH_SEL,
    PH_PKG,
    PH_DIG,
    PH_NEED,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    logic       accepted;
    logic [4:0] version_start;
    logic [5:0] version_length;
  } rtvc_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_tail_char(input logic [7:0] c);
    return is_alnum(c) || (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT) ||
           (c == CH_TILDE) || (c == CH_AT);
  endfunction

  // "refs/tags/"
  function automatic logic [7:0] refs_char(input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = 8'h72;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h66;
      4'd3:    c = 8'h73;
      4'd4:    c = 8'h2F;
      4'd5:    c = 8'h74;
      4'd6:    c = 8'h61;
      4'd7:    c = 8'h67;
      4'd8:    c = 8'h73;
      4'd9:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Seven-byte packaging prefix, starting with 'd' and ending in '/'
  function automatic logic [7:0] pkgpfx_char(input logic [3:0] k);
    logic [7:0] c;
    case (k)
      4'd0:    c = 8'h64;
      4'd1:    c = 8'h65;
      4'd2:    c = 8'h62;
      4'd3:    c = 8'h69;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h2F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/rtvc_parser.sv -----
// ----------------------------------------------------------------------------
// rtvc_parser
// Per-character prefix and version scanner with its state registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtvc_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_valid,
  input  logic [7:0]            character,
  input  logic                  end_of_name,
  input  logic [5:0]            max_len,
  output rtvc_pkg::rtvc_result_t verdict
);

  rtvc_pkg::phase_t phase, phase_next;
  logic [3:0] match_count, match_count_next;
  logic [4:0] offset, offset_next;
  logic [6:0] count, count_next;
  logic       rejected, rejected_next;

  logic             begin_en;
  logic [4:0]       begin_off;
  logic             take_en;
  logic             sel_en;
  logic [4:0]       sel_base;
  logic             refs_ok;
  rtvc_pkg::phase_t vphase;
  logic [6:0]       vcount;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= rtvc_pkg::PH_START;
      match_count <= 4'd0;
      offset      <= 5'd0;
      count       <= 7'd0;
      rejected    <= 1'b0;
    end else begin
      phase       <= phase_next;
      match_count <= match_count_next;
      offset      <= offset_next;
      count       <= count_next;
      rejected    <= rejected_next;
    end
  end

  // Next state
  always_comb begin
    phase_next       = phase;
    match_count_next = match_count;
    offset_next      = offset;
    count_next       = count;
    rejected_next    = rejected;
    begin_en         = 1'b0;
    begin_off        = 5'd0;
    take_en          = 1'b0;
    sel_en           = 1'b0;
    sel_base         = 5'd0;
    refs_ok          = 1'b0;
    vphase           = phase;
    vcount           = count;

    if (step_valid && end_of_name) begin
      phase_next       = rtvc_pkg::PH_START;
      match_count_next = 4'd0;
      offset_next      = 5'd0;
      count_next       = 7'd0;
      rejected_next    = 1'b0;
    end else if (step_valid && !rejected) begin
      case (phase)
        rtvc_pkg::PH_START: begin
          sel_en   = 1'b1;
          sel_base = 5'd0;
          refs_ok  = 1'b1;
        end
        rtvc_pkg::PH_REFS: begin
          if ((match_count < rtvc_pkg::REFS_LEN) &&
              (character == rtvc_pkg::refs_char(match_count))) begin
            match_count_next = match_count + 4'd1;
            if (match_count_next == rtvc_pkg::REFS_LEN) begin
              phase_next = rtvc_pkg::PH_SEL;
            end
          end else if (match_count == 4'd1) begin
            // lone leading r: one-letter prefix after all
            begin_en  = 1'b1;
            begin_off = 5'd1;
            take_en   = 1'b1;
          end else begin
            rejected_next = 1'b1;
          end
        end
        rtvc_pkg::PH_SEL: begin
          sel_en   = 1'b1;
          sel_base = rtvc_pkg::REFS_BASE;
        end
        rtvc_pkg::PH_PKG: begin
          if ((match_count < rtvc_pkg::PKGPFX_LEN) &&
              (character == rtvc_pkg::pkgpfx_char(match_count))) begin
            match_count_next = match_count + 4'd1;
            if (match_count_next == rtvc_pkg::PKGPFX_LEN) begin
              begin_en  = 1'b1;
              begin_off = offset + 5'd7;
            end
          end else begin
            rejected_next = 1'b1;
          end
        end
        rtvc_pkg::PH_DIG, rtvc_pkg::PH_NEED, rtvc_pkg::PH_TAIL: begin
          take_en = 1'b1;
        end
        default: begin
          rejected_next = 1'b1;
        end
      endcase

      if (sel_en) begin
        if (refs_ok && (character == rtvc_pkg::CH_LOW_R)) begin
          phase_next       = rtvc_pkg::PH_REFS;
          match_count_next = 4'd1;
        end else if ((character == rtvc_pkg::CH_LOW_V) || (character == rtvc_pkg::CH_UP_V) ||
                     (character == rtvc_pkg::CH_LOW_R) || (character == rtvc_pkg::CH_UP_R)) begin
          begin_en  = 1'b1;
          begin_off = sel_base + 5'd1;
        end else if (character == rtvc_pkg::CH_LOW_D) begin
          phase_next       = rtvc_pkg::PH_PKG;
          match_count_next = 4'd1;
          offset_next      = sel_base;
        end else begin
          begin_en  = 1'b1;
          begin_off = sel_base;
          take_en   = 1'b1;
        end
      end

      if (begin_en) begin
        offset_next = (begin_off > rtvc_pkg::MAX_NAME_OFFSET) ? rtvc_pkg::MAX_NAME_OFFSET
                                                              : begin_off;
        count_next  = 7'd0;
        phase_next  = rtvc_pkg::PH_DIG;
        vphase      = rtvc_pkg::PH_DIG;
        vcount      = 7'd0;
      end

      if (take_en) begin
        count_next = (vcount < rtvc_pkg::COUNT_TOP) ? vcount + 7'd1 : vcount;
        case (vphase)
          rtvc_pkg::PH_DIG: begin
            if (character == rtvc_pkg::CH_DOT) begin
              phase_next = rtvc_pkg::PH_NEED;
            end else if (!rtvc_pkg::is_digit(character)) begin
              rejected_next = 1'b1;
            end
          end
          rtvc_pkg::PH_NEED: begin
            if (rtvc_pkg::is_digit(character)) begin
              phase_next = rtvc_pkg::PH_TAIL;
            end else begin
              rejected_next = 1'b1;
            end
          end
          default: begin
            if (!rtvc_pkg::is_tail_char(character)) begin
              rejected_next = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Verdict for the name seen so far
  always_comb begin
    verdict = '0;
    if (!rejected && (phase == rtvc_pkg::PH_TAIL) && (count <= {1'b0, max_len})) begin
      verdict.accepted       = 1'b1;
      verdict.version_start  = offset;
      verdict.version_length = count[5:0];
    end
  end

endmodule

// ----- rtl/core/release_tag_version_checker.sv -----
// ----------------------------------------------------------------------------
// release_tag_version_checker
// Streams a tag name one byte per request and reports, on the closing
// request, whether the name is a release tag and where its version sits.
// ----------------------------------------------------------------------------
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// input    | in_valid / in_ready        | character, end_of_name
// result   | out_valid / out_ready      | accepted, version_start, version_length
// config   | cfg_valid / cfg_ready      | max_version_length
//
// Throughput is one request per cycle while no held result blocks a closing
// request; the per-byte scanner update is the only work and fits between the
// input register and the state registers. A closing request passes the input
// register, then loads the result register and out_valid. Reset (rst,
// synchronous) empties both stages and sets the length limit to 32. A held
// result stalls a closing request and all behind it. cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "release_tag_version_checker_macros.svh"

module release_tag_version_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       end_of_name,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [4:0] version_start,
  output logic [5:0] version_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] max_version_length
);

  // Length limit register
  logic [5:0] max_len;

  // Input stage: holds one request in front of the scanner
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eon;
  logic       s1_go;

  rtvc_pkg::rtvc_result_t verdict;

  // Result field summaries for the checks below
  logic       no_version;
  logic       start_known;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= rtvc_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len <= max_version_length;
    end
  end

  // Advance the input stage unless a closing request meets a full,
  // stalled result register.
  assign s1_go    = s1_valid && (!s1_eon || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= character;
      s1_eon  <= end_of_name;
    end
  end

  rtvc_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step_valid  (s1_go),
    .character   (s1_char),
    .end_of_name (s1_eon),
    .max_len     (max_len),
    .verdict     (verdict)
  );

  // Result register: load on a closing request, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_eon) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_eon) begin
      accepted       <= verdict.accepted;
      version_start  <= verdict.version_start;
      version_length <= verdict.version_length;
    end
  end

  assign no_version  = (version_start == 5'd0) && (version_length == 6'd0);
  assign start_known = (version_start == 5'd0) || (version_start == 5'd1) ||
                       (version_start == 5'd7) || (version_start == 5'd10) ||
                       (version_start == 5'd11) || (version_start == 5'd17);

  // A stall at the input can only come from a closing request blocked by
  // a held result.
  `RTVC_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, s1_valid && s1_eon && out_valid && !out_ready)

  // A rejected name reports zero offset and length.
  `RTVC_ASSERT_NOW(a_reject_zero, clk, rst, out_valid && !accepted, no_version)

  // Version text holds at least a dot and one digit.
  `RTVC_ASSERT_NOW(a_min_length, clk, rst, out_valid && accepted, version_length >= 6'd2)

  // Only the known prefix combinations give a version offset.
  `RTVC_ASSERT_NOW(a_start_set, clk, rst, out_valid && accepted, start_known)

  // A closing request that advances always yields a result next cycle.
  `RTVC_ASSERT_NEXT(a_eon_result, clk, rst, s1_go && s1_eon, out_valid)

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for release_tag_version_checker. A driver streams
// tag names one byte per request from a queue that the stimulus process
// fills; a scanner model in the bench predicts each verdict when a closing
// request is taken; a monitor compares every result, field by field, with
// the oldest prediction. Both sides stall at random, and the length limit
// is rewritten between phases, including its extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  // Prefix texts, right-aligned, first byte at the top.
  localparam logic [79:0] REFS_TEXT    = "refs/tags/";
  localparam logic [79:0] RELEASE_TEXT = "release/";
  // Packaging prefix: 'd' through the closing '/'.
  localparam logic [79:0] PKG_TEXT     = 80'h64_65_62_69_61_6E_2F;

  typedef struct {
    logic [7:0]  ch;
    logic        eon;
    int unsigned gap;
  } name_req_t;

  // DUT ports
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] character = 8'h00;
  logic       end_of_name = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       accepted;
  logic [4:0] version_start;
  logic [5:0] version_length;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [5:0] max_version_length = rtvc_pkg::MAX_LEN_RESET;

  // Scanner model state
  rtvc_pkg::phase_t scan_phase;
  logic [3:0] match_cnt;
  logic [4:0] start_ofs;
  logic [6:0] ver_cnt;
  logic       scan_bad;
  logic [5:0] len_limit = rtvc_pkg::MAX_LEN_RESET;

  // Queues and bookkeeping
  name_req_t              req_queue[$];
  rtvc_pkg::rtvc_result_t verdict_q[$];
  logic [7:0]             name_buf[$];
  name_req_t              cur_req;
  rtvc_pkg::rtvc_result_t want;
  int unsigned  gap_count = 0;
  int unsigned  stall_left = 0;
  bit           sender_pace = 1'b1;
  bit           recv_pace = 1'b1;
  bit           hold_off = 1'b0;
  int unsigned  errors = 0;
  int unsigned  items_queued = 0;
  int unsigned  names_made = 0;
  int unsigned  results_seen = 0;
  int unsigned  n_accept = 0;
  int unsigned  n_reject = 0;
  int unsigned  n_limits = 1;

  release_tag_version_checker dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .character          (character),
    .end_of_name        (end_of_name),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .accepted           (accepted),
    .version_start      (version_start),
    .version_length     (version_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .max_version_length (max_version_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scanner model: tracks one name at a time, same rules as the block.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] text_byte(input logic [79:0] txt, input int n,
                                           input int k);
    return txt[8*(n-1-k) +: 8];
  endfunction

  function automatic bit num_char(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit version_char(input logic [7:0] c);
    return num_char(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           c == "-" || c == "_" || c == "." || c == "~" || c == "@";
  endfunction

  function automatic void clear_scan();
    scan_phase = rtvc_pkg::PH_START;
    match_cnt  = 4'd0;
    start_ofs  = 5'd0;
    ver_cnt    = 7'd0;
    scan_bad   = 1'b0;
  endfunction

  function automatic void begin_version(input logic [5:0] ofs);
    // Clamp the offset to the widest prefix combination.
    start_ofs  = (ofs > rtvc_pkg::MAX_NAME_OFFSET) ? rtvc_pkg::MAX_NAME_OFFSET : ofs[4:0];
    ver_cnt    = 7'd0;
    scan_phase = rtvc_pkg::PH_DIG;
  endfunction

  function automatic void take_version_char(input logic [7:0] c);
    // Saturate the length count; anything that long is rejected anyway.
    if (ver_cnt < rtvc_pkg::COUNT_TOP) ver_cnt = ver_cnt + 7'd1;
    case (scan_phase)
      rtvc_pkg::PH_DIG: begin
        if (c == ".") scan_phase = rtvc_pkg::PH_NEED;
        else if (!num_char(c)) scan_bad = 1'b1;
      end
      rtvc_pkg::PH_NEED: begin
        if (num_char(c)) scan_phase = rtvc_pkg::PH_TAIL;
        else scan_bad = 1'b1;
      end
      default: begin
        if (!version_char(c)) scan_bad = 1'b1;
      end
    endcase
  endfunction

  // First byte after an optional refs prefix; base is its offset.
  function automatic void select_prefix(input logic [7:0] c, input logic [4:0] base,
                                        input bit refs_ok);
    if (refs_ok && c == "r") begin
      scan_phase = rtvc_pkg::PH_REFS;
      match_cnt  = 4'd1;
    end else if (c == "v" || c == "V" || c == "r" || c == "R") begin
      begin_version({1'b0, base} + 6'd1);
    end else if (c == "d") begin
      scan_phase = rtvc_pkg::PH_PKG;
      match_cnt  = 4'd1;
      start_ofs  = base;
    end else begin
      begin_version({1'b0, base});
      take_version_char(c);
    end
  endfunction

  function automatic void scan_byte(input logic [7:0] c);
    if (scan_bad) return;
    case (scan_phase)
      rtvc_pkg::PH_START: select_prefix(c, 5'd0, 1'b1);
      rtvc_pkg::PH_REFS: begin
        if (match_cnt < rtvc_pkg::REFS_LEN &&
            c == text_byte(REFS_TEXT, 10, match_cnt)) begin
          match_cnt = match_cnt + 4'd1;
          if (match_cnt == rtvc_pkg::REFS_LEN) scan_phase = rtvc_pkg::PH_SEL;
        end else if (match_cnt == 4'd1) begin
          // Leading 'r' broken at once: treat it as a one-letter prefix.
          begin_version(6'd1);
          take_version_char(c);
        end else begin
          scan_bad = 1'b1;
        end
      end
      rtvc_pkg::PH_SEL: select_prefix(c, rtvc_pkg::REFS_BASE, 1'b0);
      rtvc_pkg::PH_PKG: begin
        if (match_cnt < rtvc_pkg::PKGPFX_LEN &&
            c == text_byte(PKG_TEXT, 7, match_cnt)) begin
          match_cnt = match_cnt + 4'd1;
          if (match_cnt == rtvc_pkg::PKGPFX_LEN) begin_version({1'b0, start_ofs} + 6'd7);
        end else begin
          scan_bad = 1'b1;
        end
      end
      rtvc_pkg::PH_DIG, rtvc_pkg::PH_NEED, rtvc_pkg::PH_TAIL: take_version_char(c);
      default: scan_bad = 1'b1;
    endcase
  endfunction

  // Closing request: queue the verdict and start the next name from scratch.
  function automatic void close_name();
    rtvc_pkg::rtvc_result_t r;
    bit ok;
    ok = !scan_bad && scan_phase == rtvc_pkg::PH_TAIL && ver_cnt <= {1'b0, len_limit};
    r.accepted       = ok;
    r.version_start  = ok ? start_ofs : 5'd0;
    r.version_length = ok ? ver_cnt[5:0] : 6'd0;
    verdict_q.push_back(r);
    if (ok) n_accept++;
    else n_reject++;
    clear_scan();
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present the next request after its drawn gap, hold it until taken,
  // and feed the model at the edge where the request is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_count = 0;
      clear_scan();
    end else begin
      if (in_valid && in_ready) begin
        if (end_of_name) close_name();
        else scan_byte(character);
      end
      if (!in_valid || in_ready) begin
        if (req_queue.size() != 0 && gap_count >= req_queue[0].gap) begin
          cur_req = req_queue.pop_front();
          in_valid    <= 1'b1;
          character   <= cur_req.ch;
          end_of_name <= cur_req.eon;
          gap_count = 0;
        end else begin
          in_valid <= 1'b0;
          if (req_queue.size() != 0) gap_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest prediction, then draw
  // how long to stall before the next one. A hold-off overrides everything.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing predicted: accepted=%0b start=%0d len=%0d",
                   $time, accepted, version_start, version_length);
        end else begin
          want = verdict_q.pop_front();
          if (accepted !== want.accepted) begin
            errors++;
            $display("%0t: accepted expected %0b, got %0b",
                     $time, want.accepted, accepted);
          end
          if (version_start !== want.version_start) begin
            errors++;
            $display("%0t: version_start expected %0d, got %0d",
                     $time, want.version_start, version_start);
          end
          if (version_length !== want.version_length) begin
            errors++;
            $display("%0t: version_length expected %0d, got %0d",
                     $time, want.version_length, version_length);
          end
        end
        stall_left = recv_pace ? $urandom_range(0, 17) : 0;
        // Switch between stalling and streaming every couple dozen results.
        if (results_seen % 24 == 0) recv_pace = ($urandom_range(0, 2) != 0);
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    name_buf.push_back(b);
  endtask

  task automatic add_text(input logic [79:0] txt, input int n);
    for (int k = 0; k < n; k++) add_byte(text_byte(txt, n, k));
  endtask

  function automatic logic [7:0] pick_version_char();
    int unsigned n;
    n = $urandom_range(0, 66);
    if (n < 10) return "0" + n;
    if (n < 36) return "a" + (n - 10);
    if (n < 62) return "A" + (n - 36);
    case (n)
      62:      return "-";
      63:      return "_";
      64:      return ".";
      65:      return "~";
      default: return "@";
    endcase
  endfunction

  // Well-formed version text of the given total length (two at least).
  task automatic add_version(input int total);
    int digits;
    int len;
    len = (total < 2) ? 2 : total;
    digits = $urandom_range(0, 3);
    if (digits > len - 2) digits = len - 2;
    repeat (digits) add_byte("0" + $urandom_range(0, 9));
    add_byte(".");
    add_byte("0" + $urandom_range(0, 9));
    repeat (len - 2 - digits) add_byte(pick_version_char());
  endtask

  // Turn the buffered bytes plus a closing request into queued requests.
  task automatic send_name();
    name_req_t r;
    foreach (name_buf[k]) begin
      r.ch  = name_buf[k];
      r.eon = 1'b0;
      r.gap = sender_pace ? $urandom_range(0, 17) : 0;
      req_queue.push_back(r);
    end
    // The closing request carries no byte; drive junk on it.
    r.ch  = $urandom_range(0, 255);
    r.eon = 1'b1;
    r.gap = sender_pace ? $urandom_range(0, 17) : 0;
    req_queue.push_back(r);
    items_queued += name_buf.size() + 1;
    names_made++;
    name_buf.delete();
  endtask

  task automatic make_random_name();
    int unsigned kind;
    int unsigned sel;
    int unsigned m;
    int vlen;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      if ($urandom_range(0, 9) < 3) add_text(REFS_TEXT, 10);
      sel = $urandom_range(0, 9);
      case (sel)
        0:       add_byte("v");
        1:       add_byte("V");
        2:       add_byte("r");
        3:       add_byte("R");
        4, 5:    add_text(PKG_TEXT, 7);
        6:       if ($urandom_range(0, 2) == 0) add_text(RELEASE_TEXT, 8);
        default: ;
      endcase
      m = $urandom_range(0, 9);
      if (m < 6) vlen = $urandom_range(2, 10);
      else if (m < 9) vlen = int'(len_limit) + $urandom_range(0, 2) - 1;
      else vlen = $urandom_range(11, 70);
      // Rarely push the length count into saturation.
      if ($urandom_range(0, 149) == 0) vlen = $urandom_range(125, 135);
      add_version(vlen);
      if (kind >= 70) begin
        // Break the name: corrupt a byte, cut it short, or cut a prefix.
        case ($urandom_range(0, 2))
          0: name_buf[$urandom_range(0, name_buf.size() - 1)] = $urandom_range(0, 255);
          1: repeat ($urandom_range(1, name_buf.size())) void'(name_buf.pop_back());
          default: begin
            name_buf.delete();
            if ($urandom_range(0, 1) == 0) begin
              m = $urandom_range(2, 9);
              add_text(REFS_TEXT >> (8 * (10 - m)), m);
            end else begin
              m = $urandom_range(1, 6);
              add_text(PKG_TEXT >> (8 * (7 - m)), m);
            end
            add_version($urandom_range(2, 6));
          end
        endcase
      end
    end else begin
      // Noise bytes, half of them drawn from the printable range.
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 1) == 0) add_byte($urandom_range(0, 255));
        else add_byte($urandom_range(32, 126));
      end
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    target = items_queued + count;
    @(negedge clk);
    while (items_queued < target) begin
      if (names_made % 16 == 0) sender_pace = ($urandom_range(0, 2) != 0);
      make_random_name();
      send_name();
    end
  endtask

  // Wait until every request is taken and every verdict is back, then let the
  // pipeline settle past its latency.
  task automatic drain();
    while (req_queue.size() != 0 || in_valid || verdict_q.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(input logic [5:0] v);
    @(posedge clk);
    cfg_valid          <= 1'b1;
    max_version_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_limit = v;
    n_limits++;
  endtask

  // Stop the receiver for a long stretch while short names keep coming, so
  // the result stage fills and closing requests back up.
  task automatic squeeze_output();
    @(negedge clk);
    sender_pace = 1'b0;
    hold_off = 1'b1;
    for (int k = 0; k < 40; k++) begin
      if (k % 2 == 0) add_text("v1.0", 4);
      send_name();
    end
    repeat (400) @(negedge clk);
    hold_off = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed names at the reset limit.
    @(negedge clk);
    add_text("v1.0", 4);  send_name();   // plain one-letter prefix
    add_text("r9.Z", 4);  send_name();   // 'r' that breaks the refs prefix at once
    add_text("d.", 2);    send_name();   // broken packaging prefix
    send_name();                         // empty name
    add_text(".7", 2);
    add_byte(8'hFF);      send_name();   // non-ASCII byte in the tail
    add_byte(8'h00);      send_name();   // zero byte
    add_text("rex", 3);   send_name();   // refs prefix broken late
    run_random(100);
    drain();

    // Limit of one, below the shortest version: nothing fits.
    write_limit(6'd1);
    run_random(110);
    drain();

    // Largest limit, with output back-pressure and a saturating name.
    write_limit(6'd63);
    squeeze_output();
    @(negedge clk);
    add_byte("v");
    add_version(130);
    send_name();
    run_random(100);
    drain();

    // Limit of zero: every name is rejected.
    write_limit(6'd0);
    run_random(80);
    drain();

    write_limit($urandom_range(2, 62));
    run_random(150);
    drain();

    write_limit(rtvc_pkg::MAX_LEN_RESET);
    run_random(150);
    drain();

    if (verdict_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted results never arrived", $time, verdict_q.size());
    end
    $display("Streamed %0d names in %0d requests across %0d length limits;",
             names_made, items_queued, n_limits);
    $display("%0d verdicts checked: %0d accepted, %0d rejected.",
             results_seen, n_accept, n_reject);
    if (errors == 0) begin
      $display("release_tag_version_checker: match");
    end else begin
      $display("release_tag_version_checker: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timed out with %0d requests pending", req_queue.size());
    $display("release_tag_version_checker: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rtvc_pkg.sv
rtl/core/rtvc_parser.sv
rtl/core/release_tag_version_checker.sv
verif/tb.sv
